// ----- hw/rtl/shamir_gf256_recover_macros.svh -----
// Assertion macros for the RTL files; sgr_back.sv includes them.
`ifndef SHAMIR_GF256_RECOVER_MACROS_SVH
`define SHAMIR_GF256_RECOVER_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define SGR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define SGR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/sgr_pkg.sv -----
`default_nettype none

package sgr_pkg;

    // Status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_FEW = 2'd1;
    localparam logic [1:0] ST_DUP = 2'd2;
    localparam logic [1:0] ST_OVF = 2'd3;

    localparam logic [7:0] MIN_SHARES_RST = 8'd2;
    localparam logic [7:0] GF_POLY_LOW    = 8'h1B;

    typedef struct packed {
        logic [7:0] share_index;
        logic [7:0] share_byte;
        logic       last_share;
    } t_share_in;

    typedef struct packed {
        logic [7:0] key_byte;
        logic [1:0] status;
    } t_result;

    // One classified share on its way to the back end
    typedef struct packed {
        logic       store;
        logic [7:0] slot;
        logic [7:0] x;
        logic [7:0] y;
        logic       last;
        logic [7:0] count;
        logic       ovf;
    } t_job;

    // Multiply in GF(2^8) modulo x^8 + x^4 + x^3 + x + 1
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = 8'd0;
        x   = a;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) begin
                acc = acc ^ x;
            end
            x = x[7] ? ((x << 1) ^ GF_POLY_LOW) : (x << 1);
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sgr_ram.sv -----
`default_nettype none

module sgr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hw/rtl/sgr_front.sv -----
`default_nettype none

module sgr_front #(
    parameter int MAX_SHARES = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire sgr_pkg::t_share_in i_in_data,
    output logic                   o_push,
    output sgr_pkg::t_job          o_job,
    input  wire logic              i_full
);
    import sgr_pkg::*;

    localparam int CW = $clog2(MAX_SHARES + 1);

    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic          room;
    logic [CW-1:0] cnt_after;
    logic          ovf_after;

    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full;
    assign room       = r_count < CW'(MAX_SHARES);
    assign cnt_after  = room ? r_count + CW'(1) : r_count;
    assign ovf_after  = r_ovf || !room;

    // Classify the share: store slot or drop, and close the group on last
    always_comb begin
        o_job.store = room;
        o_job.slot  = 8'(r_count);
        o_job.x     = i_in_data.share_index;
        o_job.y     = i_in_data.share_byte;
        o_job.last  = i_in_data.last_share;
        o_job.count = 8'(cnt_after);
        o_job.ovf   = ovf_after;
        n_count     = r_count;
        n_ovf       = r_ovf;
        if (o_push) begin
            if (i_in_data.last_share) begin
                n_count = '0;
                n_ovf   = 1'b0;
            end else begin
                n_count = cnt_after;
                n_ovf   = ovf_after;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sgr_queue.sv -----
`default_nettype none

module sgr_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire sgr_pkg::t_job i_job,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_empty,
    output sgr_pkg::t_job      o_job
);
    import sgr_pkg::*;

    t_job       r_slot [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_job   = r_slot[r_rp];

    // Two-entry ring of jobs
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_job;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sgr_back.sv -----
`default_nettype none
`include "shamir_gf256_recover_macros.svh"

module sgr_back #(
    parameter int MAX_SHARES = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [7:0]    i_min_shares,
    input  wire logic          i_empty,
    input  wire sgr_pkg::t_job i_job,
    output logic               o_pop,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output sgr_pkg::t_result   o_out_data
);
    import sgr_pkg::*;

    localparam int CW = $clog2(MAX_SHARES + 1);
    localparam int AW = $clog2(MAX_SHARES);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_CHECK = 11'b000_0000_0010,
        S_RDI   = 11'b000_0000_0100,
        S_LDI   = 11'b000_0000_1000,
        S_RDJ   = 11'b000_0001_0000,
        S_MUL   = 11'b000_0010_0000,
        S_INV   = 11'b000_0100_0000,
        S_EXP   = 11'b000_1000_0000,
        S_T1    = 11'b001_0000_0000,
        S_T2    = 11'b010_0000_0000,
        S_OUT   = 11'b100_0000_0000
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_n, n_n, r_i, n_i, r_j, n_j;
    logic          r_ovf, n_ovf;
    logic [7:0]    r_xi, n_xi, r_yi, n_yi;
    logic [7:0]    r_num, n_num, r_den, n_den, r_inv, n_inv;
    logic [3:0]    r_cnt, n_cnt;
    logic [7:0]    r_key, n_key;
    logic [1:0]    r_status, n_status;
    logic          r_out_valid, n_out_valid;
    t_result       r_out, n_out;

    logic          ram_we;
    logic [AW-1:0] ram_raddr;
    logic [15:0]   ram_rdata;
    logic [7:0]    rd_x, rd_y;
    logic          out_free;

    assign o_pop     = (r_state == S_IDLE) && !i_empty;
    assign ram_we    = o_pop && i_job.store;
    assign ram_raddr = (r_state == S_RDI) ? r_i[AW-1:0] : r_j[AW-1:0];
    assign rd_x      = ram_rdata[15:8];
    assign rd_y      = ram_rdata[7:0];
    assign out_free  = !r_out_valid || !i_out_stall;

    sgr_ram #(
        .WIDTH(16),
        .DEPTH(MAX_SHARES)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(i_job.slot[AW-1:0]),
        .i_wdata({i_job.x, i_job.y}),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Sequencer: store shares, then on the last one check the group and interpolate at zero
    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_i         = r_i;
        n_j         = r_j;
        n_ovf       = r_ovf;
        n_xi        = r_xi;
        n_yi        = r_yi;
        n_num       = r_num;
        n_den       = r_den;
        n_inv       = r_inv;
        n_cnt       = r_cnt;
        n_key       = r_key;
        n_status    = r_status;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        unique case (r_state)
            S_IDLE: begin
                if (o_pop && i_job.last) begin
                    n_n     = i_job.count[CW-1:0];
                    n_ovf   = i_job.ovf;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_i      = '0;
                n_key    = 8'd0;
                n_status = ST_OK;
                if (r_ovf) begin
                    n_status = ST_OVF;
                    n_state  = S_OUT;
                end else if (9'(r_n) < {1'b0, i_min_shares}) begin
                    n_status = ST_FEW;
                    n_state  = S_OUT;
                end else begin
                    n_state = S_RDI;
                end
            end
            S_RDI: begin
                n_state = S_LDI;
            end
            S_LDI: begin
                n_xi    = rd_x;
                n_yi    = rd_y;
                n_j     = '0;
                n_num   = 8'd1;
                n_den   = 8'd1;
                n_state = S_RDJ;
            end
            S_RDJ: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                if (r_j != r_i) begin
                    n_num = gf_mul(r_num, rd_x);
                    n_den = gf_mul(r_den, rd_x ^ r_xi);
                end
                n_j     = r_j + CW'(1);
                n_state = (r_j + CW'(1) == r_n) ? S_INV : S_RDJ;
            end
            S_INV: begin
                // A zero denominator means two shares share an index
                if (r_den == 8'd0) begin
                    n_status = ST_DUP;
                    n_state  = S_OUT;
                end else begin
                    n_inv   = r_den;
                    n_cnt   = 4'd0;
                    n_state = S_EXP;
                end
            end
            S_EXP: begin
                // Raise to 254: alternate square and multiply, end on a square
                n_inv = r_cnt[0] ? gf_mul(r_inv, r_den) : gf_mul(r_inv, r_inv);
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd12) begin
                    n_state = S_T1;
                end
            end
            S_T1: begin
                n_num   = gf_mul(r_num, r_inv);
                n_state = S_T2;
            end
            S_T2: begin
                n_key   = r_key ^ gf_mul(r_yi, r_num);
                n_i     = r_i + CW'(1);
                n_state = (r_i + CW'(1) == r_n) ? S_OUT : S_RDI;
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid    = 1'b1;
                    n_out.status   = r_status;
                    n_out.key_byte = (r_status == ST_OK) ? r_key : 8'd0;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_n      <= n_n;
        r_i      <= n_i;
        r_j      <= n_j;
        r_ovf    <= n_ovf;
        r_xi     <= n_xi;
        r_yi     <= n_yi;
        r_num    <= n_num;
        r_den    <= n_den;
        r_inv    <= n_inv;
        r_cnt    <= n_cnt;
        r_key    <= n_key;
        r_status <= n_status;
        r_out    <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `SGR_ASSERT_IMP(a_key_zero_on_error, r_out_valid && (r_out.status != ST_OK), r_out.key_byte == 8'd0, "key byte not zero on error status")
    `SGR_ASSERT_NXT(a_out_loads, (r_state == S_OUT) && !r_out_valid, r_out_valid && (r_state == S_IDLE), "result not loaded from output state")
    `SGR_ASSERT_IMP(a_loop_bounds, (r_state == S_RDJ) || (r_state == S_MUL), (r_i < r_n) && (r_j < r_n), "share loop index out of range")
    `SGR_ASSERT_IMP(a_pop_idle_only, o_pop, r_state == S_IDLE, "queue popped while busy")

endmodule

`default_nettype wire

// ----- hw/rtl/shamir_gf256_recover.sv -----
// Shamir secret recovery over GF(2^8), polynomial 0x11B. Each transfer on the
// input channel is one share (index, byte, last flag); shares are kept in a
// MAX_SHARES-entry store, and the share flagged last closes the group and
// yields one result: the Lagrange interpolation at zero, or a zero byte with
// status too few (1), repeated index (2) or store overflow (3). A share that
// is not last goes through the front end into the queue and is stored by the
// back end when idle; the two-entry queue lets the front keep taking shares
// while the back computes, until the queue is full. Back-end time per group is
// set by the single read port of the share store (one read per pair) and the
// 13-step square-and-multiply inversion per share; a group with too few shares
// or an overflow goes from the check straight to output, and a repeated index
// ends the group at the first share whose denominator comes out zero.
// min_shares is written through the cfg channel, which is always ready.
`default_nettype none

module shamir_gf256_recover #(
    parameter int MAX_SHARES = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire sgr_pkg::t_share_in i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output sgr_pkg::t_result        o_out_data,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [7:0]         i_cfg_data
);
    import sgr_pkg::*;

    logic [7:0] r_min_shares;
    logic       push, pop, full, empty;
    t_job       job_in, job_out;

    assign o_cfg_ready = 1'b1;

    // Hold the min_shares register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_shares <= MIN_SHARES_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_min_shares <= i_cfg_data;
        end
    end

    sgr_front #(
        .MAX_SHARES(MAX_SHARES)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_data (i_in_data),
        .o_push    (push),
        .o_job     (job_in),
        .i_full    (full)
    );

    sgr_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_job  (job_in),
        .o_full (full),
        .i_pop  (pop),
        .o_empty(empty),
        .o_job  (job_out)
    );

    sgr_back #(
        .MAX_SHARES(MAX_SHARES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_min_shares(r_min_shares),
        .i_empty     (empty),
        .i_job       (job_out),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
